/* src/mlr_pkg.sv */
package mlr_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  // mapping that folds the line into the first quadrant
  typedef enum logic [1:0] {
    MAP_NONE      = 2'd0,
    MAP_MIRROR_X  = 2'd1,
    MAP_ANTI_DIAG = 2'd2,
    MAP_MIRROR_Y  = 2'd3
  } map_e;

endpackage

/* src/mlr_front.sv */
module mlr_front import mlr_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  localparam int unsigned PW        = COORD_BITS + 2,
  localparam int unsigned ENTRY_W   = 3 + 6 * PW
) (
  input  logic                         action_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  output logic [ENTRY_W-1:0]           entry_o
);

  logic signed [PW-1:0] x1, y1, x2, y2;
  logic signed [PW-1:0] x1m, y1m, x2m, y2m;
  logic signed [PW-1:0] dx, dy;
  map_e                 map;

  assign x1 = PW'(start_x_i);
  assign y1 = PW'(start_y_i);
  assign x2 = PW'(end_x_i);
  assign y2 = PW'(end_y_i);

  // ordered tests, first match wins
  always_comb begin
    if (x2 <= x1 && y2 >= y1) begin
      map = MAP_MIRROR_X;
    end else if (x2 <= x1 && y2 <= y1) begin
      map = MAP_ANTI_DIAG;
    end else if (x2 >= x1 && y1 >= y2) begin
      map = MAP_MIRROR_Y;
    end else begin
      map = MAP_NONE;
    end
  end

  always_comb begin
    unique case (map)
      MAP_MIRROR_X: begin
        x1m = -x1; y1m = y1; x2m = -x2; y2m = y2;
      end
      MAP_ANTI_DIAG: begin
        x1m = -y1; y1m = -x1; x2m = -y2; y2m = -x2;
      end
      MAP_MIRROR_Y: begin
        x1m = x1; y1m = -y1; x2m = x2; y2m = -y2;
      end
      default: begin
        x1m = x1; y1m = y1; x2m = x2; y2m = y2;
      end
    endcase
  end

  assign dx = x2m - x1m;
  assign dy = y2m - y1m;

  assign entry_o = {action_i, map, x1m, y1m, x2m, y2m, dx, dy};

endmodule

/* src/mlr_queue.sv */
module mlr_queue import mlr_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] slots_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* src/mlr_back.sv */
module mlr_back import mlr_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  localparam int unsigned PW        = COORD_BITS + 2,
  localparam int unsigned DW        = COORD_BITS + 3,
  localparam int unsigned ENTRY_W   = 3 + 6 * PW
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  logic [ENTRY_W-1:0]    req_entry_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  pixel_valid_o,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic                  last_pixel_o
);

  logic                 req_action;
  logic [1:0]           req_map_raw;
  map_e                 req_map;
  logic signed [PW-1:0] ld_x1, ld_y1, ld_x2, ld_y2, ld_dx, ld_dy;
  logic                 ld_swap;
  logic signed [PW-1:0] ld_maj, ld_min, ld_end, ld_dmaj, ld_dmin;

  assign {req_action, req_map_raw, ld_x1, ld_y1, ld_x2, ld_y2, ld_dx, ld_dy} = req_entry_i;
  assign req_map = map_e'(req_map_raw);

  // line state
  logic signed [PW-1:0] major_pos_q, minor_pos_q, major_end_q;
  logic signed [PW-1:0] delta_minor_q, delta_diff_q;
  logic signed [DW-1:0] decision_q;
  logic                 axes_swapped_q, line_active_q;
  map_e                 octant_map_q;

  // output register
  logic                  out_valid_q;
  logic                  pix_valid_q, pix_last_q;
  logic [COORD_BITS-1:0] pix_x_q, pix_y_q;

  logic pop;
  assign req_ready_o = !out_valid_q || out_ready_i;
  assign pop         = req_valid_i && req_ready_o;

  // load setup: swap axes when steep, decision = dmin - floor(dmaj/2)
  assign ld_swap = ld_dy > ld_dx;
  assign ld_maj  = ld_swap ? ld_y1 : ld_x1;
  assign ld_min  = ld_swap ? ld_x1 : ld_y1;
  assign ld_end  = ld_swap ? ld_y2 : ld_x2;
  assign ld_dmaj = ld_swap ? ld_dy : ld_dx;
  assign ld_dmin = ld_swap ? ld_dx : ld_dy;

  logic signed [PW-1:0] ld_diff;
  logic signed [DW-1:0] ld_dec;
  assign ld_diff = ld_dmin - ld_dmaj;
  assign ld_dec  = DW'(ld_dmin) - (DW'(ld_dmaj) >>> 1);

  // one midpoint step
  logic signed [PW-1:0] st_maj, st_min, st_px0, st_py0, st_px, st_py;
  logic signed [DW-1:0] st_dec;
  logic                 st_last;

  always_comb begin
    st_maj = major_pos_q + PW'(1);
    st_min = minor_pos_q;
    if (decision_q[DW-1]) begin
      st_dec = decision_q + DW'(delta_minor_q);
    end else begin
      st_dec = decision_q + DW'(delta_diff_q);
      st_min = minor_pos_q + PW'(1);
    end
  end

  assign st_last = st_maj >= major_end_q;
  assign st_px0  = axes_swapped_q ? st_min : st_maj;
  assign st_py0  = axes_swapped_q ? st_maj : st_min;

  always_comb begin
    unique case (octant_map_q)
      MAP_MIRROR_X: begin
        st_px = -st_px0; st_py = st_py0;
      end
      MAP_ANTI_DIAG: begin
        st_px = -st_py0; st_py = -st_px0;
      end
      MAP_MIRROR_Y: begin
        st_px = st_px0; st_py = -st_py0;
      end
      default: begin
        st_px = st_px0; st_py = st_py0;
      end
    endcase
  end

  logic do_step;
  assign do_step = pop && (req_action == ACT_STEP) && line_active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      major_pos_q    <= '0;
      minor_pos_q    <= '0;
      major_end_q    <= '0;
      delta_minor_q  <= '0;
      delta_diff_q   <= '0;
      decision_q     <= '0;
      axes_swapped_q <= 1'b0;
      octant_map_q   <= MAP_NONE;
      line_active_q  <= 1'b0;
    end else if (pop && (req_action == ACT_LOAD)) begin
      major_pos_q    <= ld_maj;
      minor_pos_q    <= ld_min;
      major_end_q    <= ld_end;
      delta_minor_q  <= ld_dmin;
      delta_diff_q   <= ld_diff;
      decision_q     <= ld_dec;
      axes_swapped_q <= ld_swap;
      octant_map_q   <= req_map;
      line_active_q  <= ld_dmaj > '0;
    end else if (do_step) begin
      major_pos_q   <= st_maj;
      minor_pos_q   <= st_min;
      decision_q    <= st_dec;
      line_active_q <= !st_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      pix_valid_q <= do_step;
      pix_last_q  <= do_step && st_last;
      pix_x_q     <= do_step ? st_px[COORD_BITS-1:0] : '0;
      pix_y_q     <= do_step ? st_py[COORD_BITS-1:0] : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_valid_o = pix_valid_q;
  assign pixel_x_o     = pix_x_q;
  assign pixel_y_o     = pix_y_q;
  assign last_pixel_o  = pix_last_q;

  a_last_is_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!pix_last_q || pix_valid_q))
    else $error("last flag on a result without a pixel");

  a_active_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_active_q |-> (major_pos_q < major_end_q))
    else $error("active line already at its end");

  a_end_clears_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_step && st_last) |=> !line_active_q)
    else $error("line still active after its last pixel");

  a_step_needs_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && req_action == ACT_STEP && !line_active_q) |=> (out_valid_q && !pix_valid_q))
    else $error("step without a line produced a pixel");

endmodule

/* src/midpoint_line_rasterizer_unit.sv */
// Midpoint line rasterizer for all octants. A request with tuser = 0 loads a
// line (start and end point) and answers with an empty result; a request with
// tuser = 1 asks for the next pixel and answers with it, tlast marking the end
// point, or with an empty result (tuser low) when no line is pending. The start
// point is never emitted. Every request gives exactly one result. Throughput is
// one request per clock when the result side is not stalled: the classifier
// feeds a two-entry queue and the stepper updates the decision term, both axes
// and the unmapping in the same cycle. A request passes through a queue slot
// and then the output register before its result appears.
module midpoint_line_rasterizer_unit import mlr_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  localparam int unsigned IN_W      = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W     = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // start_x, start_y, end_x, end_y
  input  logic             s_axis_tuser,   // action
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,   // pixel_x, pixel_y
  output logic             m_axis_tuser,   // pixel_valid
  output logic             m_axis_tlast
);

  localparam int unsigned PW      = COORD_BITS + 2;
  localparam int unsigned ENTRY_W = 3 + 6 * PW;

  logic [ENTRY_W-1:0]    push_entry, pop_entry;
  logic                  q_valid, q_ready;
  logic [COORD_BITS-1:0] pixel_x, pixel_y;

  mlr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .action_i  (s_axis_tuser),
    .start_x_i ($signed(s_axis_tdata[COORD_BITS-1:0])),
    .start_y_i ($signed(s_axis_tdata[2*COORD_BITS-1:COORD_BITS])),
    .end_x_i   ($signed(s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS])),
    .end_y_i   ($signed(s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS])),
    .entry_o   (push_entry)
  );

  mlr_queue #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (s_axis_tvalid),
    .push_ready_o (s_axis_tready),
    .push_data_i  (push_entry),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (pop_entry)
  );

  mlr_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (q_valid),
    .req_ready_o   (q_ready),
    .req_entry_i   (pop_entry),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .pixel_valid_o (m_axis_tuser),
    .pixel_x_o     (pixel_x),
    .pixel_y_o     (pixel_y),
    .last_pixel_o  (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_W'({pixel_y, pixel_x});

endmodule
